// File: hdl/pngunf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG unfilter package
// Shared constants, register indexes, filter codes and the job record that
// passes from the front end to the reconstruction back end.
// ----------------------------------------------------------------------------
package pngunf_pkg;

	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int BYTES_PER_PIXEL = 4;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 16;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	localparam logic [2:0] FILT_NONE  = 3'd0;
	localparam logic [2:0] FILT_SUB   = 3'd1;
	localparam logic [2:0] FILT_UP    = 3'd2;
	localparam logic [2:0] FILT_AVG   = 3'd3;
	localparam logic [2:0] FILT_PAETH = 3'd4;

	localparam logic [7:0] FILT_MAX_CODE = 8'd4;

	localparam int QUEUE_DEPTH = 4;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] sample;
		logic [2:0] filter;
		logic       bad;
		logic       last;
		logic       first_row;
	} job_t;

	function automatic logic [7:0] absdiff8(input logic [7:0] x, input logic [7:0] y);
		absdiff8 = (x > y) ? (x - y) : (y - x);
	endfunction

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
	                                     input logic [7:0] c);
		logic [8:0] pa;
		logic [8:0] pb;
		logic [8:0] pc;
		logic [8:0] sum_ab;
		logic [8:0] dbl_c;
		pa     = {1'b0, absdiff8(b, c)};
		pb     = {1'b0, absdiff8(a, c)};
		sum_ab = {1'b0, a} + {1'b0, b};
		dbl_c  = {c, 1'b0};
		pc     = (sum_ab > dbl_c) ? (sum_ab - dbl_c) : (dbl_c - sum_ab);
		if (pa <= pb && pa <= pc) begin
			paeth = a;
		end else if (pb <= pc) begin
			paeth = b;
		end else begin
			paeth = c;
		end
	endfunction

endpackage
`default_nettype wire

// File: hdl/png_scanline_unfilter_rgba8_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG scanline unfilter, 8-bit RGBA
// Rebuilds filtered PNG rows (None, Sub, Up, Average, Paeth) byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   Set image_width (index 0) and image_height (index 1) on the cfg port while
//   no image is in progress. Feed the decompressed stream on stream_byte with
//   in_valid; the first byte of every row is its filter type and yields no
//   item. Every sample byte yields one item on pixel_byte, with bad_filter set
//   for rows whose type byte exceeded 4 and last_of_image on the final byte.
//   An item is taken on either channel when valid is high and stall is low.
// Timing:
//   Each sample byte passes through a queue slot, the stage-one register and
//   the output register. One byte is taken every cycle while in_stall is low.
//   The line store is read one stage ahead of the filter arithmetic and
//   written as each result leaves that stage. A four-entry queue between the
//   front end and the back end absorbs output stalls; in_stall rises only when
//   that queue is full. Filter type bytes are taken even then.
// Reset:
//   Width and height return to 1 and the block waits for a filter type byte.
//   The line store is not cleared; the first row of an image does not use it.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_rgba8_unit
	import pngunf_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire logic [7:0]            stream_byte,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      logic [7:0]            pixel_byte,
	output      logic                  bad_filter,
	output      logic                  last_of_image
);

	localparam int COL_W  = $clog2(MAX_WIDTH * BYTES_PER_PIXEL);
	localparam int JOB_W  = $bits(job_t);
	localparam int DATA_W = JOB_W + COL_W;

	logic              push;
	job_t              push_job;
	logic [COL_W-1:0]  push_col;
	logic              q_full;
	logic              q_pop;
	logic              q_nonempty;
	logic [DATA_W-1:0] q_data;
	job_t              q_job;
	logic [COL_W-1:0]  q_col;

	assign q_job = q_data[DATA_W-1:COL_W];
	assign q_col = q_data[COL_W-1:0];

	pngunf_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.COL_W     (COL_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.stream_byte (stream_byte),
		.q_full      (q_full),
		.push        (push),
		.push_job    (push_job),
		.push_col    (push_col)
	);

	pngunf_queue #(
		.DATA_W (DATA_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_job, push_col}),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.pop_data  (q_data)
	);

	pngunf_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.COL_W     (COL_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_nonempty),
		.q_job         (q_job),
		.q_col         (q_col),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_byte    (pixel_byte),
		.bad_filter    (bad_filter),
		.last_of_image (last_of_image)
	);

endmodule
`default_nettype wire

// File: hdl/pngunf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG unfilter front end
// Holds the size registers, takes stream bytes, consumes filter type bytes
// and tags each sample byte with its column, filter and row position.
// ----------------------------------------------------------------------------
module pngunf_front
	import pngunf_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int COL_W     = $clog2(DEF_MAX_WIDTH * BYTES_PER_PIXEL)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire logic [7:0]            stream_byte,
	input  wire logic                  q_full,
	output      logic                  push,
	output      job_t                  push_job,
	output      logic [COL_W-1:0]      push_col
);

	localparam int LEN_W = COL_W + 1;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic                awaiting_q;
	logic [2:0]          filter_q;
	logic                bad_q;
	logic [COL_W-1:0]    col_q;
	logic [HEIGHT_W-1:0] row_q;

	logic [LEN_W-1:0]    w_eff;
	logic [LEN_W-1:0]    row_len;
	logic [HEIGHT_W-1:0] h_eff;
	logic                end_row;
	logic                last_row;
	logic                accept;

	always_comb begin
		if (width_q == '0) begin
			w_eff = LEN_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = LEN_W'(MAX_WIDTH);
		end else begin
			w_eff = LEN_W'(width_q);
		end
	end

	assign row_len  = w_eff << 2;
	assign h_eff    = (height_q == '0) ? HEIGHT_W'(1) : height_q;
	assign end_row  = (LEN_W'(col_q) + LEN_W'(1)) >= row_len;
	assign last_row = ((HEIGHT_W + 1)'(row_q) + (HEIGHT_W + 1)'(1)) >= {1'b0, h_eff};

	assign in_stall = !awaiting_q && q_full;
	assign accept   = in_valid && !in_stall;
	assign push     = accept && !awaiting_q;

	assign push_job.sample    = stream_byte;
	assign push_job.filter    = filter_q;
	assign push_job.bad       = bad_q;
	assign push_job.last      = end_row && last_row;
	assign push_job.first_row = (row_q == '0);
	assign push_col           = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(1);
			height_q <= HEIGHT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b1;
			filter_q   <= FILT_NONE;
			bad_q      <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (accept) begin
			if (awaiting_q) begin
				if (stream_byte > FILT_MAX_CODE) begin
					filter_q <= FILT_NONE;
					bad_q    <= 1'b1;
				end else begin
					filter_q <= stream_byte[2:0];
					bad_q    <= 1'b0;
				end
				col_q      <= '0;
				awaiting_q <= 1'b0;
			end else if (end_row) begin
				awaiting_q <= 1'b1;
				col_q      <= '0;
				row_q      <= last_row ? '0 : row_q + HEIGHT_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// The byte that closes an image leaves the front waiting for a new first row.
	a_image_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_job.last |=> awaiting_q && row_q == '0)
		else $error("front did not wrap after the last byte of the image");

endmodule
`default_nettype wire

// File: hdl/pngunf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG unfilter job queue
// Short register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module pngunf_queue
	import pngunf_pkg::*;
#(
	parameter int DATA_W = $bits(job_t)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	output      logic              full,
	input  wire logic              pop,
	output      logic              nonempty,
	output      logic [DATA_W-1:0] pop_data
);

	logic [DATA_W-1:0]  slot_q [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full     = (count_q == Q_CNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
				                                                   : wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
				                                                   : rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("item pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("item popped from an empty queue");

endmodule
`default_nettype wire

// File: hdl/pngunf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG unfilter back end
// Reads the row above from the line store, applies the filter rule of the
// row and delivers reconstructed bytes through an output register.
// ----------------------------------------------------------------------------
module pngunf_back
	import pngunf_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int COL_W     = $clog2(DEF_MAX_WIDTH * BYTES_PER_PIXEL)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire job_t             q_job,
	input  wire logic [COL_W-1:0] q_col,
	output      logic             pop,
	output      logic             out_valid,
	input  wire logic             out_stall,
	output      logic [7:0]       pixel_byte,
	output      logic             bad_filter,
	output      logic             last_of_image
);

	localparam int DEPTH = MAX_WIDTH * BYTES_PER_PIXEL;

	logic [7:0]       line_mem [DEPTH];

	logic             valid_s1;
	job_t             job_s1;
	logic [COL_W-1:0] col_s1;
	logic [7:0]       above_s1;

	logic [7:0]       left_q    [BYTES_PER_PIXEL];
	logic [7:0]       upleft_q  [BYTES_PER_PIXEL];

	logic             out_valid_q;
	logic [7:0]       pixel_q;
	logic             bad_q;
	logic             last_q;

	logic             s1_move;
	logic             s1_load;
	logic [1:0]       ch;
	logic             first_pixel;
	logic [7:0]       a;
	logic [7:0]       b;
	logic [7:0]       c;
	logic [8:0]       sum_ab;
	logic [7:0]       pred;
	logic [7:0]       res;

	assign s1_move = valid_s1 && (!out_valid_q || !out_stall);
	assign s1_load = !valid_s1 || s1_move;
	assign pop     = q_valid && s1_load;

	assign ch          = col_s1[1:0];
	assign first_pixel = ((col_s1 >> 2) == '0);
	assign a           = first_pixel ? 8'd0 : left_q[ch];
	assign c           = first_pixel ? 8'd0 : upleft_q[ch];
	assign b           = job_s1.first_row ? 8'd0 : above_s1;
	assign sum_ab      = {1'b0, a} + {1'b0, b};

	always_comb begin
		case (job_s1.filter)
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = sum_ab[8:1];
			FILT_PAETH: pred = paeth(a, b, c);
			default:    pred = 8'd0;
		endcase
	end

	assign res = job_s1.sample + pred;

	always_ff @(posedge clk) begin
		if (pop) begin
			job_s1   <= q_job;
			col_s1   <= q_col;
			above_s1 <= line_mem[q_col];
		end
		if (s1_move) begin
			line_mem[col_s1] <= res;
			pixel_q          <= res;
			bad_q            <= job_s1.bad;
			last_q           <= job_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < BYTES_PER_PIXEL; i++) begin
				left_q[i]   <= 8'd0;
				upleft_q[i] <= 8'd0;
			end
		end else begin
			if (s1_load) begin
				valid_s1 <= q_valid;
			end
			if (s1_move) begin
				out_valid_q  <= 1'b1;
				left_q[ch]   <= res;
				upleft_q[ch] <= b;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_byte    = pixel_q;
	assign bad_filter    = bad_q;
	assign last_of_image = last_q;

	// A stage held behind a stalled output keeps its item.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_move |=> valid_s1 && $stable(col_s1) && $stable(job_s1))
		else $error("stage one item changed while held");

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter testbench
// Drives images of random filtered rows through the unfilter at one
// byte per item, with random input gaps and output stalls. A scoreboard
// rebuilds every sample byte with its own line store and filter arithmetic
// and checks each output item against it. Image size registers are changed
// only between images, over settings including zero sizes and 65535 rows.
// ----------------------------------------------------------------------------
module tb
	import pngunf_pkg::*;
;

	localparam int CLK_HALF   = 6;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 850;
	localparam int LINE_BYTES = DEF_MAX_WIDTH * BYTES_PER_PIXEL;

	typedef struct {
		logic [7:0] px;
		logic       bad;
		logic       last;
	} pixel_t;

	class unfilter_scoreboard;
		logic [10:0] width_reg;
		logic [15:0] height_reg;
		logic [7:0]  row_above[LINE_BYTES];
		logic [31:0] left_px;
		logic [31:0] upleft_px;
		int unsigned col_cnt;
		int unsigned row_cnt;
		logic [2:0]  filt;
		bit          want_filter;
		bit          bad_row;
		pixel_t      expected_q[$];
		int          errors;
		int          checked;
		int          images;
		int          rows_by[6];

		function new();
			width_reg   = 11'd1;
			height_reg  = 16'd1;
			foreach (row_above[i]) row_above[i] = 8'h00;
			left_px     = '0;
			upleft_px   = '0;
			col_cnt     = 0;
			row_cnt     = 0;
			filt        = FILT_NONE;
			want_filter = 1'b1;
			bad_row     = 1'b0;
			errors      = 0;
			checked     = 0;
			images      = 0;
			foreach (rows_by[i]) rows_by[i] = 0;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
			if (idx == REG_WIDTH) begin
				width_reg = d[10:0];
			end else begin
				height_reg = d;
			end
		endfunction

		function int unsigned row_bytes();
			int unsigned w;
			w = width_reg;
			if (w == 0) w = 1;
			if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
			return w * BYTES_PER_PIXEL;
		endfunction

		function logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
		                                input logic [7:0] c);
			int p;
			int da;
			int db;
			int dc;
			p  = int'(a) + int'(b) - int'(c);
			da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
			db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
			dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
			if (da <= db && da <= dc) return a;
			if (db <= dc) return b;
			return c;
		endfunction

		function void note_byte(input logic [7:0] x);
			int unsigned ht;
			int unsigned col;
			int unsigned sh;
			logic [7:0]  a;
			logic [7:0]  b;
			logic [7:0]  c;
			logic [7:0]  pr;
			logic [7:0]  res;
			bit          end_row;
			bit          last_row;
			pixel_t      e;
			if (want_filter) begin
				if (x > FILT_MAX_CODE) begin
					filt    = FILT_NONE;
					bad_row = 1'b1;
					rows_by[5]++;
				end else begin
					filt    = x[2:0];
					bad_row = 1'b0;
					rows_by[x[2:0]]++;
				end
				col_cnt     = 0;
				left_px     = '0;
				upleft_px   = '0;
				want_filter = 1'b0;
				return;
			end
			ht  = (height_reg == 0) ? 1 : height_reg;
			col = col_cnt % LINE_BYTES;
			sh  = (col % 4) * 8;
			a   = left_px[sh +: 8];
			b   = (row_cnt == 0) ? 8'h00 : row_above[col];
			c   = upleft_px[sh +: 8];
			case (filt)
				FILT_SUB:   pr = a;
				FILT_UP:    pr = b;
				FILT_AVG:   pr = ({1'b0, a} + {1'b0, b}) >> 1;
				FILT_PAETH: pr = paeth_pick(a, b, c);
				default:    pr = 8'h00;
			endcase
			res = x + pr;
			row_above[col]    = res;
			left_px[sh +: 8]  = res;
			upleft_px[sh +: 8] = b;
			end_row  = (col_cnt + 1) >= row_bytes();
			last_row = (row_cnt + 1) >= ht;
			e.px   = res;
			e.bad  = bad_row;
			e.last = end_row && last_row;
			expected_q.push_back(e);
			if (end_row) begin
				want_filter = 1'b1;
				col_cnt     = 0;
				row_cnt     = last_row ? 0 : (row_cnt + 1) & 16'hFFFF;
			end else begin
				col_cnt = (col_cnt + 1) & 12'hFFF;
			end
		endfunction

		function void check_pixel(input logic [7:0] px, input logic bad, input logic last);
			pixel_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual pixel_byte %02h",
				         $time, px);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (px !== e.px) begin
				$display("%0t: pixel_byte expected %02h actual %02h", $time, e.px, px);
				errors++;
			end
			if (bad !== e.bad) begin
				$display("%0t: bad_filter expected %b actual %b", $time, e.bad, bad);
				errors++;
			end
			if (last !== e.last) begin
				$display("%0t: last_of_image expected %b actual %b", $time, e.last, last);
				errors++;
			end
			if (e.last) images++;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [7:0]            stream_byte;
	logic                  out_valid;
	logic                  out_stall;
	logic [7:0]            pixel_byte;
	logic                  bad_filter;
	logic                  last_of_image;

	unfilter_scoreboard sb = new();

	int unsigned cur_w = 1;
	int unsigned cur_h = 1;
	int          src_rate = 0;
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;
	int          bytes_sent = 0;
	int          settings = 0;

	png_scanline_unfilter_rgba8_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.stream_byte  (stream_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_byte   (pixel_byte),
		.bad_filter   (bad_filter),
		.last_of_image(last_of_image)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall) sb.note_byte(stream_byte);
			if (out_valid && !out_stall) sb.check_pixel(pixel_byte, bad_filter, last_of_image);
		end
	end

	initial begin : sink
		int burst;
		int hold_left;
		int win;
		int sink_rate;
		bit held;
		burst     = 0;
		hold_left = 0;
		win       = 0;
		sink_rate = 0;
		held      = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			win++;
			if (win >= 200) begin
				win       = 0;
				sink_rate = $urandom_range(0, 3);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!held && hold_req) begin
				held      = 1'b1;
				hold_left = 80;
				out_stall <= 1'b1;
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) < sink_rate) begin
				burst = $urandom_range(0, 4);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("tb: no item moved for %0d cycles", STALL_LIMIT);
		$display("tb: failure");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(0, 7) < src_rate) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid    <= 1'b1;
		stream_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_filter();
		int r;
		r = $urandom_range(0, 9);
		if (r < 8) return 8'($urandom_range(0, 4));
		if (r == 8) return 8'($urandom_range(5, 255));
		return 8'hFF;
	endfunction

	function automatic logic [7:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 8'h00;
		if (r == 1) return 8'hFF;
		if (r == 2) return 8'($urandom_range(0, 3));
		return 8'($urandom);
	endfunction

	task automatic send_row();
		send_byte(pick_filter());
		repeat (cur_w * BYTES_PER_PIXEL) send_byte(pick_sample());
	endtask

	task automatic send_image();
		src_rate = quiet ? 0 : $urandom_range(0, 3);
		repeat (cur_h) send_row();
	endtask

	task automatic set_size(input int unsigned w, input int unsigned h);
		int unsigned wm;
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data  <= {5'($urandom_range(0, 31)), w[10:0]};
		@(negedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data  <= h[15:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		wm    = w & 32'h7FF;
		cur_w = (wm == 0) ? 1 : ((wm > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : wm);
		cur_h = (h[15:0] == 0) ? 1 : h[15:0];
		settings++;
	endtask

	initial begin : stimulus
		int start_count;
		int unsigned w;
		int unsigned h;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_WIDTH;
		cfg_data    = '0;
		in_valid    = 1'b0;
		stream_byte = 8'h00;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset size of one pixel, with an out-of-range filter type.
		send_byte(8'd5);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'h01);

		set_size(2, 2);
		send_byte(FILT_SUB);
		repeat (4) send_byte(8'hFF);
		repeat (4) send_byte(8'h01);
		send_byte(FILT_PAETH);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(8'h80);
		send_byte(8'h01);
		send_byte(8'hFE);
		send_byte(8'h00);
		send_byte(8'hFF);

		// The receiver holds off for a long stretch while this image streams in.
		set_size(8, 3);
		hold_req = 1'b1;
		send_image();

		start_count = bytes_sent;
		while (bytes_sent - start_count < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       w = 0;
				1:       w = $urandom_range(9, 40);
				default: w = $urandom_range(1, 8);
			endcase
			h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
			set_size(w, h);
			repeat ($urandom_range(1, 3)) send_image();
		end

		// Tallest image setting, run without any gaps until the end.
		quiet = 1'b1;
		set_size($urandom_range(1, 3), 65535);
		src_rate = 0;
		repeat (60) send_row();

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("tb: %0d bytes sent, %0d pixel bytes checked, %0d images, %0d size settings",
		         bytes_sent, sb.checked, sb.images, settings);
		$display("tb: rows none/sub/up/avg/paeth/invalid = %0d/%0d/%0d/%0d/%0d/%0d",
		         sb.rows_by[0], sb.rows_by[1], sb.rows_by[2], sb.rows_by[3],
		         sb.rows_by[4], sb.rows_by[5]);
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/pngunf_pkg.sv
hdl/pngunf_front.sv
hdl/pngunf_queue.sv
hdl/pngunf_back.sv
hdl/png_scanline_unfilter_rgba8_unit.sv
sim/tb.sv
